// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL, empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CPLL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CPLL_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) cond |=> prop) else $error(msg);
`else
`define CPLL_ASSERT(lbl, clk, rstn, prop, msg)
`define CPLL_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg)
`endif
`endif

// ===== rtl/core/cpll_pkg.sv =====
// Shared constants, codes and command/status types of the pseudo-layer lookup.
package cpll_pkg;
    localparam int TABLE_DEPTH = 128;
    localparam int COORD_BITS  = 20;
    localparam int VAL_W       = 20;
    localparam int IDX_W       = 7;
    localparam int CNT8_W      = 8;
    localparam int LAYER_W     = 8;
    localparam int STATUS_W    = 2;
    localparam int CMD_W       = 2;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 2);
    localparam int SQ_W        = 2 * COORD_BITS;
    localparam int CMP_W       = (COORD_BITS > VAL_W) ? COORD_BITS : VAL_W;
    localparam int STEP_W      = $clog2(COORD_BITS);
    localparam int S_FIELDS_W  = 3 * COORD_BITS + IDX_W + VAL_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = 8;
    localparam int CFG_IDX_W   = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_BARR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WR_ENDC = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSVD    = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BARREL_INNER_R = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BARREL_OUTER_R = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENDCAP_OUTER_R = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENDCAP_INNER_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENDCAP_OUTER_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BARREL_COUNT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ENDCAP_COUNT   = 3'd6;

    // table read address select
    localparam logic [1:0] RD_MID = 2'd0;
    localparam logic [1:0] RD_LOW = 2'd1;
    localparam logic [1:0] RD_HIT = 2'd2;

    typedef struct packed {
        logic       wr_barrel;
        logic       wr_endcap;
        logic       load_in;
        logic       square;
        logic       sum;
        logic       root_step;
        logic       sel;
        logic       bs_init;
        logic       rd;
        logic [1:0] rd_sel;
        logic       bs_cmp;
        logic       lo_keep;
        logic       rec_none;
        logic       rec_zero;
        logic       rec_near;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic bs_done;
        logic hit_none;
        logic hit_zero;
    } dp_status_t;
endpackage

// ===== rtl/core/cpll_dpath.sv =====
// Datapath: config registers, layer tables, square root and binary search units.
module cpll_dpath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  cpll_pkg::dp_cmd_t                    cmd,
    output cpll_pkg::dp_status_t                 status,
    input  logic                                 cfg_we,
    input  logic [cpll_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cpll_pkg::VAL_W-1:0]           cfg_data,
    input  logic signed [cpll_pkg::COORD_BITS-1:0] x_pos,
    input  logic signed [cpll_pkg::COORD_BITS-1:0] y_pos,
    input  logic signed [cpll_pkg::COORD_BITS-1:0] z_pos,
    input  logic [cpll_pkg::IDX_W-1:0]           entry_index,
    input  logic [cpll_pkg::VAL_W-1:0]           entry_value,
    output logic [cpll_pkg::LAYER_W-1:0]         pseudo_layer,
    output logic [cpll_pkg::STATUS_W-1:0]        result_status
);
    localparam int C  = cpll_pkg::COORD_BITS;
    localparam int V  = cpll_pkg::VAL_W;
    localparam int N  = cpll_pkg::CNT_W;
    localparam int A  = cpll_pkg::ADDR_W;
    localparam int Q  = cpll_pkg::SQ_W;
    localparam int W  = cpll_pkg::CMP_W;

    logic [V-1:0] barrel_inner_r_reg, barrel_outer_r_reg, endcap_outer_r_reg;
    logic [V-1:0] endcap_inner_z_reg, endcap_outer_z_reg;
    logic [cpll_pkg::CNT8_W-1:0] barrel_count_reg, endcap_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            barrel_inner_r_reg <= '0;
            barrel_outer_r_reg <= '0;
            endcap_outer_r_reg <= '0;
            endcap_inner_z_reg <= '0;
            endcap_outer_z_reg <= '0;
            barrel_count_reg   <= cpll_pkg::CNT8_W'(1);
            endcap_count_reg   <= cpll_pkg::CNT8_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                cpll_pkg::REG_BARREL_INNER_R: barrel_inner_r_reg <= cfg_data;
                cpll_pkg::REG_BARREL_OUTER_R: barrel_outer_r_reg <= cfg_data;
                cpll_pkg::REG_ENDCAP_OUTER_R: endcap_outer_r_reg <= cfg_data;
                cpll_pkg::REG_ENDCAP_INNER_Z: endcap_inner_z_reg <= cfg_data;
                cpll_pkg::REG_ENDCAP_OUTER_Z: endcap_outer_z_reg <= cfg_data;
                cpll_pkg::REG_BARREL_COUNT:   barrel_count_reg <= cfg_data[cpll_pkg::CNT8_W-1:0];
                cpll_pkg::REG_ENDCAP_COUNT:   endcap_count_reg <= cfg_data[cpll_pkg::CNT8_W-1:0];
                default: ;
            endcase
        end
    end

    // layer tables
    logic [V-1:0] barrel_mem [cpll_pkg::TABLE_DEPTH];
    logic [V-1:0] endcap_mem [cpll_pkg::TABLE_DEPTH];
    logic [31:0]  wr_idx32;
    logic         wr_in_range;
    logic [A-1:0] wr_addr;

    assign wr_idx32    = 32'(entry_index);
    assign wr_in_range = wr_idx32 < 32'(cpll_pkg::TABLE_DEPTH);
    assign wr_addr     = wr_idx32[A-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.wr_barrel && wr_in_range) begin
            barrel_mem[wr_addr] <= entry_value;
        end
        if (cmd.wr_endcap && wr_in_range) begin
            endcap_mem[wr_addr] <= entry_value;
        end
    end

    // absolute values, squares, root
    logic [C-1:0] ax_reg, ay_reg, az_reg;
    logic [Q-1:0] sqx_reg, sqy_reg, rem_reg, res_reg, bit_reg;
    logic [Q-1:0] trial;
    logic [C-1:0] r_val;

    assign trial = res_reg + bit_reg;
    assign r_val = res_reg[C-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            ax_reg <= x_pos[C-1] ? (~x_pos + C'(1)) : x_pos;
            ay_reg <= y_pos[C-1] ? (~y_pos + C'(1)) : y_pos;
            az_reg <= z_pos[C-1] ? (~z_pos + C'(1)) : z_pos;
        end
        if (cmd.square) begin
            sqx_reg <= Q'(ax_reg) * Q'(ax_reg);
            sqy_reg <= Q'(ay_reg) * Q'(ay_reg);
        end
        if (cmd.sum) begin
            rem_reg <= sqx_reg + sqy_reg;
            res_reg <= '0;
            bit_reg <= Q'(1) << (Q - 2);
        end else if (cmd.root_step) begin
            if (rem_reg >= trial) begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // search over the loaded entries of the selected table, edge checked last
    logic [N-1:0] nb, ne, n_sel;
    logic [V-1:0] edge_sel;
    logic [W-1:0] pos;
    logic [N-1:0] lo_reg, hi_reg, mid_reg, mid, rd_addr;
    logic [N:0]   mid_sum;
    logic [V-1:0] rd_b_reg, rd_e_reg, lo_val_reg;
    logic         rd_edge_reg, sel_reg;
    logic [W-1:0] fetch_val;

    assign nb = (32'(barrel_count_reg) > 32'(cpll_pkg::TABLE_DEPTH))
              ? N'(cpll_pkg::TABLE_DEPTH) : N'(barrel_count_reg);
    assign ne = (32'(endcap_count_reg) > 32'(cpll_pkg::TABLE_DEPTH))
              ? N'(cpll_pkg::TABLE_DEPTH) : N'(endcap_count_reg);
    assign n_sel    = cmd.sel ? ne : nb;
    assign edge_sel = cmd.sel ? endcap_outer_z_reg : barrel_outer_r_reg;
    assign pos      = cmd.sel ? W'(az_reg) : W'(r_val);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[N:1];

    always_comb begin
        unique case (cmd.rd_sel)
            cpll_pkg::RD_LOW: rd_addr = lo_reg - N'(1);
            cpll_pkg::RD_HIT: rd_addr = lo_reg;
            default:          rd_addr = mid;
        endcase
    end

    assign fetch_val = rd_edge_reg ? W'(edge_sel)
                     : (sel_reg ? W'(rd_e_reg) : W'(rd_b_reg));

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_b_reg    <= barrel_mem[rd_addr[A-1:0]];
            rd_e_reg    <= endcap_mem[rd_addr[A-1:0]];
            rd_edge_reg <= rd_addr >= n_sel;
            sel_reg     <= cmd.sel;
            mid_reg     <= mid;
        end
        if (cmd.bs_init) begin
            lo_reg <= '0;
            hi_reg <= n_sel;
        end else if (cmd.bs_cmp) begin
            if (fetch_val > pos) begin
                hi_reg <= mid_reg;
            end else begin
                lo_reg <= mid_reg + N'(1);
            end
        end
        if (cmd.lo_keep) begin
            lo_val_reg <= fetch_val[V-1:0];
        end
    end

    assign status.bs_done  = lo_reg >= hi_reg;
    assign status.hit_none = (lo_reg == n_sel) && !(W'(edge_sel) > pos);
    assign status.hit_zero = lo_reg == '0;

    // nearest of the two neighbors, ties go up
    logic signed [W:0] dl, du, dl_abs, du_abs;
    logic [N-1:0]      near_layer;

    assign dl     = $signed({1'b0, pos}) - $signed({1'b0, W'(lo_val_reg)});
    assign du     = $signed({1'b0, fetch_val}) - $signed({1'b0, pos});
    assign dl_abs = dl[W] ? -dl : dl;
    assign du_abs = du[W] ? -du : du;
    assign near_layer = (dl_abs < du_abs) ? (lo_reg - N'(1)) : lo_reg;

    logic         ok_b_reg, ok_e_reg;
    logic [N-1:0] lay_b_reg, lay_e_reg;
    logic         rec_ok;
    logic [N-1:0] rec_layer;

    assign rec_ok    = !cmd.rec_none;
    assign rec_layer = cmd.rec_near ? near_layer : '0;

    always_ff @(posedge aclk) begin
        if (cmd.rec_none || cmd.rec_zero || cmd.rec_near) begin
            if (cmd.sel) begin
                ok_e_reg  <= rec_ok;
                lay_e_reg <= rec_layer;
            end else begin
                ok_b_reg  <= rec_ok;
                lay_b_reg <= rec_layer;
            end
        end
    end

    // region decision and result
    logic [V-1:0]  rmax;
    logic          outside;
    logic          res_ok;
    logic [N-1:0]  res_layer;
    logic [N-1:0]  both_layer;

    assign rmax = (barrel_outer_r_reg > endcap_outer_r_reg)
                ? barrel_outer_r_reg : endcap_outer_r_reg;
    assign outside = (W'(az_reg) > W'(endcap_outer_z_reg)) || (W'(r_val) > W'(rmax));
    assign both_layer = (lay_b_reg > lay_e_reg) ? lay_b_reg : lay_e_reg;

    always_comb begin
        priority if (W'(az_reg) < W'(endcap_inner_z_reg)) begin
            res_ok    = ok_b_reg;
            res_layer = lay_b_reg;
        end else if (W'(r_val) < W'(barrel_inner_r_reg)) begin
            res_ok    = ok_e_reg;
            res_layer = lay_e_reg;
        end else begin
            res_ok    = ok_b_reg || ok_e_reg;
            res_layer = both_layer;
        end
    end

    logic [cpll_pkg::LAYER_W-1:0]  layer_out_reg;
    logic [cpll_pkg::STATUS_W-1:0] status_out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (outside) begin
                layer_out_reg  <= '0;
                status_out_reg <= cpll_pkg::ST_OUTSIDE;
            end else if (!res_ok) begin
                layer_out_reg  <= '0;
                status_out_reg <= cpll_pkg::ST_NOMATCH;
            end else begin
                layer_out_reg  <= (32'(res_layer) >= 32'd254)
                                ? cpll_pkg::LAYER_W'(255)
                                : cpll_pkg::LAYER_W'(32'(res_layer) + 32'd1);
                status_out_reg <= cpll_pkg::ST_FOUND;
            end
        end
    end

    assign pseudo_layer  = layer_out_reg;
    assign result_status = status_out_reg;
endmodule

// ===== rtl/core/cpll_ctrl.sv =====
// Controller: sequences root, table searches and output handshake.
module cpll_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cpll_pkg::CMD_W-1:0]    command,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cpll_pkg::dp_cmd_t             cmd,
    input  cpll_pkg::dp_status_t          status
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SQ     = 4'd1;
    localparam logic [3:0] S_SUM    = 4'd2;
    localparam logic [3:0] S_ROOT   = 4'd3;
    localparam logic [3:0] S_INIT   = 4'd4;
    localparam logic [3:0] S_RD     = 4'd5;
    localparam logic [3:0] S_CMP    = 4'd6;
    localparam logic [3:0] S_LO_GET = 4'd7;
    localparam logic [3:0] S_UP_GET = 4'd8;
    localparam logic [3:0] S_NEXT   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]                    state_reg, state_next;
    logic [cpll_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          sel_reg, sel_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          accept;

    assign in_ready  = state_reg == S_IDLE;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.sel        = sel_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.wr_barrel = command == cpll_pkg::CMD_WR_BARR;
                    cmd.wr_endcap = command == cpll_pkg::CMD_WR_ENDC;
                    if (command == cpll_pkg::CMD_QUERY) begin
                        cmd.load_in = 1'b1;
                        state_next  = S_SQ;
                    end
                end
            end
            S_SQ: begin
                cmd.square = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                step_next  = '0;
                state_next = S_ROOT;
            end
            S_ROOT: begin
                cmd.root_step = 1'b1;
                step_next     = step_reg + cpll_pkg::STEP_W'(1);
                if (32'(step_reg) == 32'(cpll_pkg::COORD_BITS - 1)) begin
                    sel_next   = 1'b0;
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                cmd.bs_init = 1'b1;
                state_next  = S_RD;
            end
            S_RD: begin
                if (!status.bs_done) begin
                    cmd.rd     = 1'b1;
                    cmd.rd_sel = cpll_pkg::RD_MID;
                    state_next = S_CMP;
                end else if (status.hit_none) begin
                    cmd.rec_none = 1'b1;
                    state_next   = S_NEXT;
                end else if (status.hit_zero) begin
                    cmd.rec_zero = 1'b1;
                    state_next   = S_NEXT;
                end else begin
                    cmd.rd     = 1'b1;
                    cmd.rd_sel = cpll_pkg::RD_LOW;
                    state_next = S_LO_GET;
                end
            end
            S_CMP: begin
                cmd.bs_cmp = 1'b1;
                state_next = S_RD;
            end
            S_LO_GET: begin
                cmd.lo_keep = 1'b1;
                cmd.rd      = 1'b1;
                cmd.rd_sel  = cpll_pkg::RD_HIT;
                state_next  = S_UP_GET;
            end
            S_UP_GET: begin
                cmd.rec_near = 1'b1;
                state_next   = S_NEXT;
            end
            S_NEXT: begin
                if (!sel_reg) begin
                    sel_next   = 1'b1;
                    state_next = S_INIT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ===== rtl/core/calorimeter_pseudo_layer_lookup_core.sv =====
// Top level of the calorimeter pseudo-layer lookup core.
//
//  channel | direction | handshake           | contents
//  s_      | in        | s_tvalid/s_tready   | query or table write request
//  m_      | out       | m_tvalid/m_tready   | pseudo layer and status per query
//  cfg_    | in        | cfg_valid/cfg_ready | register index and value
//
// A table write or the unused command code is done in the cycle that takes it.
// A query: squaring and summing, 20 root steps (one bit per cycle), then per table an
// init state, up to 8 search steps (read, then compare) on the single read port and an
// edge check, neighbor reads and hand-over, then a result state; a new request is taken
// only once the result is loaded, which waits while a stalled result holds the output.
// Reset (aresetn low, synchronous) returns the controller to idle, drops any
// pending result and loads register defaults; table contents survive reset.
// A stalled result sits in the output register while the next request is taken.
`include "assert_macros.svh"
module calorimeter_pseudo_layer_lookup_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // x_pos, y_pos, z_pos, entry_index, entry_value, zero fill
    input  logic [cpll_pkg::S_TDATA_W-1:0]       s_tdata,
    // command
    input  logic [cpll_pkg::CMD_W-1:0]           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pseudo_layer
    output logic [cpll_pkg::M_TDATA_W-1:0]       m_tdata,
    // status
    output logic [cpll_pkg::STATUS_W-1:0]        m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cpll_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cpll_pkg::VAL_W-1:0]           cfg_data
);
    localparam int C  = cpll_pkg::COORD_BITS;
    localparam int I0 = 3 * C;
    localparam int V0 = I0 + cpll_pkg::IDX_W;

    cpll_pkg::dp_cmd_t    cmd;
    cpll_pkg::dp_status_t status;
    logic [cpll_pkg::LAYER_W-1:0] pseudo_layer;

    // registers accept a request every cycle
    assign cfg_ready = 1'b1;

    cpll_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .command   (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    cpll_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .x_pos         ($signed(s_tdata[C-1:0])),
        .y_pos         ($signed(s_tdata[2*C-1:C])),
        .z_pos         ($signed(s_tdata[3*C-1:2*C])),
        .entry_index   (s_tdata[V0-1:I0]),
        .entry_value   (s_tdata[V0+cpll_pkg::VAL_W-1:V0]),
        .pseudo_layer  (pseudo_layer),
        .result_status (m_tuser)
    );

    assign m_tdata = cpll_pkg::M_TDATA_W'(pseudo_layer);

    // a query occupies the core; a table write leaves it free
    `CPLL_ASSERT_NEXT(a_query_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser == cpll_pkg::CMD_QUERY, !s_tready, "query did not occupy core")
    `CPLL_ASSERT_NEXT(a_write_free, aclk, aresetn, s_tvalid && s_tready && s_tuser != cpll_pkg::CMD_QUERY, s_tready, "write left core busy")
    `CPLL_ASSERT(a_err_zero, aclk, aresetn, m_tvalid && m_tuser != cpll_pkg::ST_FOUND |-> m_tdata == '0, "error result with nonzero layer")
    `CPLL_ASSERT(a_found_nz, aclk, aresetn, m_tvalid && m_tuser == cpll_pkg::ST_FOUND |-> m_tdata != '0, "found result with zero layer")
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the calorimeter pseudo-layer lookup core.
module tb_top;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASES = 4;
    localparam int PHASE_QUERIES = 64;

    typedef struct packed {
        logic [cpll_pkg::CMD_W-1:0] command;
        logic [19:0]      x_pos;
        logic [19:0]      y_pos;
        logic [19:0]      z_pos;
        logic [6:0]       entry_index;
        logic [19:0]      entry_value;
    } request_t;

    typedef struct packed {
        logic [7:0]                    layer;
        logic [cpll_pkg::STATUS_W-1:0] status;
    } layer_result_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [cpll_pkg::S_TDATA_W-1:0] s_tdata;
    logic [cpll_pkg::CMD_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [cpll_pkg::M_TDATA_W-1:0] m_tdata;
    logic [cpll_pkg::STATUS_W-1:0] m_tuser;
    logic cfg_valid;
    logic cfg_ready;
    logic [cpll_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cpll_pkg::VAL_W-1:0] cfg_data;

    calorimeter_pseudo_layer_lookup_core dut (.*);

    // Mirror of block state used for prediction
    logic [19:0] barrel_pos [cpll_pkg::TABLE_DEPTH];
    logic [19:0] endcap_pos [cpll_pkg::TABLE_DEPTH];
    logic [19:0] inner_r, outer_r, ec_outer_r, ec_inner_z, ec_outer_z;
    logic [7:0]  barrel_cnt, endcap_cnt;

    request_t      pending_requests[$];
    layer_result_t expected_layers[$];
    bit            failed;
    bit            burst_on;
    bit            s_tready_seen;
    int            burst_left;
    int            idle_cycles;
    int            stall_phase;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void add_request(request_t rq);
        pending_requests.insert(pending_requests.size(), rq);
    endfunction

    function automatic void expect_result(layer_result_t res);
        expected_layers.insert(expected_layers.size(), res);
    endfunction

    function automatic logic [19:0] magnitude(logic [19:0] v);
        return v[19] ? (~v + 20'd1) : v;
    endfunction

    function automatic logic [20:0] root_floor(logic [40:0] n);
        logic [40:0] res;
        logic [41:0] bitv;
        res = '0;
        bitv = 42'd1 << 40;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[20:0];
    endfunction

    // Nearest layer in one table with its outer edge as an implicit entry.
    function automatic bit nearest_layer(logic [20:0] pos, bit barrel, output int layer);
        int n, hit;
        longint lo, up, dl, du;
        logic [19:0] e;
        n = barrel ? barrel_cnt : endcap_cnt;
        if (n > cpll_pkg::TABLE_DEPTH) n = cpll_pkg::TABLE_DEPTH;
        hit = n + 1;
        layer = 0;
        for (int i = 0; i <= n; i++) begin
            if (i < n) e = barrel ? barrel_pos[i] : endcap_pos[i];
            else e = barrel ? outer_r : ec_outer_z;
            if ({1'b0, e} > pos) begin
                hit = i;
                break;
            end
        end
        if (hit > n) return 0;
        if (hit == 0) return 1;
        lo = (hit - 1 < n) ? (barrel ? barrel_pos[hit-1] : endcap_pos[hit-1])
                           : (barrel ? outer_r : ec_outer_z);
        up = (hit < n) ? (barrel ? barrel_pos[hit] : endcap_pos[hit])
                       : (barrel ? outer_r : ec_outer_z);
        dl = longint'(pos) - lo;
        du = up - longint'(pos);
        if (dl < 0) dl = -dl;
        if (du < 0) du = -du;
        layer = (dl < du) ? hit - 1 : hit;
        return 1;
    endfunction

    // Apply one accepted request to the mirror and queue its result if any.
    task automatic predict_lookup(request_t rq);
        logic [20:0] ax, ay, az, r, rmax;
        int layer, lb, le;
        bit okb, oke;
        layer_result_t res;
        if (rq.command == cpll_pkg::CMD_WR_BARR) begin
            barrel_pos[rq.entry_index] = rq.entry_value;
        end else if (rq.command == cpll_pkg::CMD_WR_ENDC) begin
            endcap_pos[rq.entry_index] = rq.entry_value;
        end else if (rq.command == cpll_pkg::CMD_QUERY) begin
            ax = magnitude(rq.x_pos);
            ay = magnitude(rq.y_pos);
            az = magnitude(rq.z_pos);
            // the most negative value maps to its own magnitude 2^19
            if (rq.x_pos == 20'h80000) ax = 21'h80000;
            if (rq.y_pos == 20'h80000) ay = 21'h80000;
            if (rq.z_pos == 20'h80000) az = 21'h80000;
            r = root_floor(41'(ax) * 41'(ax) + 41'(ay) * 41'(ay));
            rmax = (outer_r > ec_outer_r) ? outer_r : ec_outer_r;
            res.status = cpll_pkg::ST_FOUND;
            layer = 0;
            if (az > ec_outer_z || r > rmax) begin
                res.status = cpll_pkg::ST_OUTSIDE;
            end else if (az < ec_inner_z) begin
                if (!nearest_layer(r, 1, layer)) res.status = cpll_pkg::ST_NOMATCH;
            end else if (r < inner_r) begin
                if (!nearest_layer(az, 0, layer)) res.status = cpll_pkg::ST_NOMATCH;
            end else begin
                okb = nearest_layer(r, 1, lb);
                oke = nearest_layer(az, 0, le);
                if (!okb) lb = 0;
                if (!oke) le = 0;
                if (!okb && !oke) res.status = cpll_pkg::ST_NOMATCH;
                else layer = (lb > le) ? lb : le;
            end
            res.layer = (res.status != cpll_pkg::ST_FOUND) ? 8'd0 :
                        (layer >= 254) ? 8'd255 : 8'(layer + 1);
            expect_result(res);
        end
    endtask

    // Driver: bursts of requests from the pending queue with random gaps.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready_seen) begin
            if (burst_left == 0) begin
                burst_on = !burst_on;
                burst_left = burst_on ? $urandom_range(1, 30) : $urandom_range(0, 80);
            end
            if (burst_on && pending_requests.size() > 0) begin
                request_t rq;
                rq = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= rq.command;
                s_tdata <= {{(cpll_pkg::S_TDATA_W-cpll_pkg::S_FIELDS_W){1'b0}},
                            rq.entry_value, rq.entry_index, rq.z_pos, rq.y_pos, rq.x_pos};
                burst_left--;
            end else begin
                s_tvalid <= 1'b0;
                if (burst_left > 0) burst_left--;
            end
        end
    end

    // Request acceptance is sampled at the rising edge.
    always @(posedge aclk) begin
        s_tready_seen <= 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            request_t rq;
            rq.command = s_tuser;
            {rq.entry_value, rq.entry_index, rq.z_pos, rq.y_pos, rq.x_pos} =
                s_tdata[cpll_pkg::S_FIELDS_W-1:0];
            predict_lookup(rq);
            s_tready_seen <= 1'b1;
        end
    end

    // Receiver stall pattern: long ready runs, short stalls, some random.
    always @(negedge aclk) begin
        stall_phase++;
        if (!aresetn) m_tready <= 1'b0;
        else if ((stall_phase / 500) % 3 == 0) m_tready <= 1'b1;
        else if ((stall_phase % 17) < 5) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_layers.size() == 0) begin
                $display("%0t: unexpected result layer %0d status %0d",
                         $time, m_tdata, m_tuser);
                failed = 1;
            end else begin
                layer_result_t ex;
                ex = expected_layers.pop_front();
                if (m_tdata != ex.layer) begin
                    $display("%0t: pseudo_layer expected %0d actual %0d",
                             $time, ex.layer, m_tdata);
                    failed = 1;
                end
                if (m_tuser != ex.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, ex.status, m_tuser);
                    failed = 1;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Write one register and hold until the handshake completes.
    task automatic write_reg(logic [cpll_pkg::CFG_IDX_W-1:0] idx, logic [19:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            cpll_pkg::REG_BARREL_INNER_R: inner_r = val;
            cpll_pkg::REG_BARREL_OUTER_R: outer_r = val;
            cpll_pkg::REG_ENDCAP_OUTER_R: ec_outer_r = val;
            cpll_pkg::REG_ENDCAP_INNER_Z: ec_inner_z = val;
            cpll_pkg::REG_ENDCAP_OUTER_Z: ec_outer_z = val;
            cpll_pkg::REG_BARREL_COUNT:   barrel_cnt = val[7:0];
            cpll_pkg::REG_ENDCAP_COUNT:   endcap_cnt = val[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every queued request is taken and every result has come.
    task automatic drain;
        while (pending_requests.size() > 0 || s_tvalid || expected_layers.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic request_t write_req(bit barrel, int idx, logic [19:0] val);
        request_t rq;
        rq = '0;
        rq.command = barrel ? cpll_pkg::CMD_WR_BARR : cpll_pkg::CMD_WR_ENDC;
        rq.entry_index = 7'(idx);
        rq.entry_value = val;
        return rq;
    endfunction

    function automatic request_t query_req(logic [19:0] x, logic [19:0] y, logic [19:0] z);
        request_t rq;
        rq = '0;
        rq.command = cpll_pkg::CMD_QUERY;
        rq.x_pos = x;
        rq.y_pos = y;
        rq.z_pos = z;
        rq.entry_index = 7'($urandom);
        rq.entry_value = 20'($urandom);
        return rq;
    endfunction

    // Load ascending leading entries of both tables into the pending queue.
    task automatic queue_tables(int nb, int ne, int step);
        int acc;
        acc = $urandom_range(0, step);
        for (int i = 0; i < nb; i++) begin
            add_request(write_req(1, i, 20'(acc)));
            acc += $urandom_range(0, step);
        end
        acc = $urandom_range(0, step);
        for (int i = 0; i < ne; i++) begin
            add_request(write_req(0, i, 20'(acc)));
            acc += $urandom_range(0, step);
        end
    endtask

    function automatic logic [19:0] rand_coord(int span);
        int v;
        v = $urandom_range(0, 2 * span) - span;
        return 20'(v);
    endfunction

    initial begin
        request_t rq;
        int span;
        int bcnt, ecnt;
        aclk = 1'b0;
        failed = 0;
        burst_on = 0;
        burst_left = 0;
        stall_phase = 0;
        idle_cycles = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = cpll_pkg::CMD_QUERY;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = cpll_pkg::REG_BARREL_INNER_R;
        cfg_data = '0;
        inner_r = 0; outer_r = 0; ec_outer_r = 0; ec_inner_z = 0; ec_outer_z = 0;
        barrel_cnt = 1; endcap_cnt = 1;
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: fill tables, then extremes and corner cases.
        queue_tables(cpll_pkg::TABLE_DEPTH, cpll_pkg::TABLE_DEPTH, 4000);
        drain();
        write_reg(cpll_pkg::REG_BARREL_INNER_R, 20'd0);
        write_reg(cpll_pkg::REG_BARREL_OUTER_R, 20'hFFFFF);
        write_reg(cpll_pkg::REG_ENDCAP_OUTER_R, 20'hFFFFF);
        write_reg(cpll_pkg::REG_ENDCAP_INNER_Z, 20'd0);
        write_reg(cpll_pkg::REG_ENDCAP_OUTER_Z, 20'hFFFFF);
        write_reg(cpll_pkg::REG_BARREL_COUNT, 20'd128);
        write_reg(cpll_pkg::REG_ENDCAP_COUNT, 20'd128);
        add_request(query_req(20'h80000, 20'h80000, 20'h80000));
        add_request(query_req(20'h7FFFF, 20'h7FFFF, 20'h7FFFF));
        add_request(query_req(20'h0, 20'h0, 20'h0));
        add_request(query_req(20'hFFFFF, 20'h1, 20'hFFFFF));
        rq = query_req(20'h12345, 20'h0, 20'h0);
        rq.command = cpll_pkg::CMD_RSVD;  // unused code: dropped
        add_request(rq);
        add_request(write_req(1, 127, 20'hFFFFF));
        add_request(query_req(20'h7FFFF, 20'h0, 20'h0));
        drain();
        // Outside, no-match, zero and saturated counts.
        write_reg(cpll_pkg::REG_ENDCAP_OUTER_Z, 20'd1000);
        write_reg(cpll_pkg::REG_BARREL_OUTER_R, 20'd500);
        write_reg(cpll_pkg::REG_ENDCAP_OUTER_R, 20'd2000);
        write_reg(cpll_pkg::REG_BARREL_COUNT, 20'd0);
        write_reg(cpll_pkg::REG_ENDCAP_COUNT, 20'd255);
        write_reg(cpll_pkg::REG_ENDCAP_INNER_Z, 20'd200);
        write_reg(cpll_pkg::REG_BARREL_INNER_R, 20'd300);
        add_request(query_req(20'd100, 20'd0, 20'd1001));
        add_request(query_req(20'd1500, 20'd0, 20'd10));
        add_request(query_req(20'd600, 20'd0, 20'd10));
        add_request(query_req(20'd400, 20'd0, 20'd500));
        add_request(query_req(20'd100, 20'd0, 20'd500));
        add_request(query_req(20'd250, 20'd0, 20'd100));
        drain();

        // Random phases with a range of geometries; only loaded entries are searched.
        for (int ph = 0; ph < PHASES; ph++) begin
            span = (ph % 2) ? 524287 : $urandom_range(50, 8000);
            bcnt = (ph == 3) ? 255 : $urandom_range(0, 128);
            ecnt = (ph == 2) ? 0 : $urandom_range(1, 200);
            queue_tables((bcnt > cpll_pkg::TABLE_DEPTH) ? cpll_pkg::TABLE_DEPTH : bcnt,
                         (ecnt > cpll_pkg::TABLE_DEPTH) ? cpll_pkg::TABLE_DEPTH : ecnt,
                         (span / 64) + 1);
            drain();
            write_reg(cpll_pkg::REG_BARREL_INNER_R, 20'($urandom_range(0, span)));
            write_reg(cpll_pkg::REG_BARREL_OUTER_R, 20'($urandom_range(0, span * 2)));
            write_reg(cpll_pkg::REG_ENDCAP_OUTER_R, 20'($urandom_range(0, span * 2)));
            write_reg(cpll_pkg::REG_ENDCAP_INNER_Z, 20'($urandom_range(0, span)));
            write_reg(cpll_pkg::REG_ENDCAP_OUTER_Z, 20'($urandom_range(0, span * 2)));
            write_reg(cpll_pkg::REG_BARREL_COUNT, 20'(bcnt));
            write_reg(cpll_pkg::REG_ENDCAP_COUNT, 20'(ecnt));
            for (int k = 0; k < PHASE_QUERIES; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    rq = query_req(20'($urandom), 20'($urandom), 20'($urandom));
                    rq.command = cpll_pkg::CMD_W'($urandom_range(0, 3));
                    // rewrite slot 0 with its own value to keep the table ascending
                    if (rq.command == cpll_pkg::CMD_WR_BARR) begin
                        rq.entry_index = '0;
                        rq.entry_value = barrel_pos[0];
                    end else if (rq.command == cpll_pkg::CMD_WR_ENDC) begin
                        rq.entry_index = '0;
                        rq.entry_value = endcap_pos[0];
                    end
                end else begin
                    rq = query_req(rand_coord(span), rand_coord(span), rand_coord(span * 2));
                end
                add_request(rq);
            end
            drain();
        end

        if (!failed) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/cpll_pkg.sv
rtl/core/cpll_dpath.sv
rtl/core/cpll_ctrl.sv
rtl/core/calorimeter_pseudo_layer_lookup_core.sv
dv/tb_top.sv
